// ===== hdl/gwm_pkg.sv =====
`default_nettype none

package gwm_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_SUBJECT = 2'd2,
    ACT_END     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    TK_LIT  = 2'd0,
    TK_ANY  = 2'd1,
    TK_STAR = 2'd2
  } tok_kind_e;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_NOMATCH  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_PATHNAME     = 2'd0,
    CFG_LEAD_PERIOD  = 2'd1,
    CFG_NO_ESCAPE    = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_PERIOD    = 8'h2E;

endpackage

`default_nettype wire

// ===== hdl/gwm_star_closure.sv =====
`default_nettype none

// Segmented prefix OR: closed[b] is set when some raw[j], j <= b, is set and
// every position j+1..b propagates (the token in front of it is a star).
module gwm_star_closure #(
  parameter int N = 65
) (
  input  wire logic [N-1:0] raw_i,
  input  wire logic [N-1:0] prop_i,
  output logic      [N-1:0] closed_o
);

  localparam int LVL = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] g [LVL+1];
  logic [N-1:0] p [LVL];

  assign g[0] = raw_i;
  assign p[0] = prop_i;

  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    localparam int D = 1 << l;
    for (genvar b = 0; b < N; b++) begin : g_bit
      if (b >= D) begin : g_comb
        assign g[l+1][b] = g[l][b] | (p[l][b] & g[l][b-D]);
        if (l < LVL - 1) begin : g_p
          assign p[l+1][b] = p[l][b] & p[l][b-D];
        end
      end else begin : g_pass
        assign g[l+1][b] = g[l][b];
        if (l < LVL - 1) begin : g_p
          assign p[l+1][b] = p[l][b];
        end
      end
    end
  end

  assign closed_o = g[LVL];

endmodule

`default_nettype wire

// ===== hdl/glob_wildcard_matcher_core.sv =====
// Wildcard matcher ('?', '*', backslash escape) over a streamed subject.
// Input stream: tuser carries the action (clear pattern, append pattern byte,
// subject byte, end of subject), tdata carries the byte. Only the end action
// produces an output word, whose tdata holds the status (matched, not
// matched, pattern too long). Pattern bytes are decoded into up to PAT_LEN
// tokens held in flops; each subject byte updates a PAT_LEN+1 bit match set
// in parallel, closed over runs of stars by a log-depth prefix network.
// Throughput: one word per cycle for every action, unless an end word waits
// on an unread status. A word is loaded into the input register at accept and
// processed there; an end word's status is loaded into the output register as
// the word leaves the input register, and m_axis_tvalid_o rises with it. The
// match-set update loop (compare, mask, star closure) sets the cycle time.
// When the output register holds an unread status, the input register still
// drains pattern and subject words; an end word waits there, and tready drops
// only then. Reset empties the pattern, clears the mode bits, restarts the
// subject and drops both registers. Mode bits are written through cfg_*.
`default_nettype none

module glob_wildcard_matcher_core #(
  parameter int PAT_LEN = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // config write port
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [0:0] cfg_data_i,
  // input stream
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] char_byte
  input  wire logic [1:0] s_axis_tuser_i,   // [1:0] action
  // output stream
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic      [7:0] m_axis_tdata_o    // [1:0] status, [7:2] zero
);

  localparam int CNT_W = $clog2(PAT_LEN + 1);
  localparam int IDX_W = (PAT_LEN > 1) ? $clog2(PAT_LEN) : 1;
  localparam int NPOS  = PAT_LEN + 1;

  // config
  logic path_mode_q, lead_period_q, no_escape_q;

  // input register
  logic                s1_valid_q;
  gwm_pkg::action_e    s1_action_q;
  logic [7:0]          s1_char_q;
  logic                s1_adv;

  // output register
  logic                out_valid_q;
  gwm_pkg::status_e    out_status_q;

  // pattern
  gwm_pkg::tok_kind_e  tok_kind_q [PAT_LEN];
  logic [7:0]          tok_byte_q [PAT_LEN];
  logic [CNT_W-1:0]    tok_count_q, tok_count_d;
  logic [CNT_W-1:0]    lead_stars_q, lead_stars_d;
  logic                esc_pend_q, esc_pend_d;
  logic                pat_ovf_q, pat_ovf_d;

  // subject
  logic [NPOS-1:0]     active_q;
  logic                at_start_q, at_start_d;
  logic                period_fail_q, period_fail_d;

  logic                tok_we;
  logic [IDX_W-1:0]    tok_waddr;
  gwm_pkg::tok_kind_e  tok_wkind;
  logic [7:0]          tok_wbyte;

  logic [NPOS-1:0]     start_set, active_eff, step_raw, step_prop, step_closed;
  logic                wild_ok;
  gwm_pkg::status_e    end_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_mode_q   <= 1'b0;
      lead_period_q <= 1'b0;
      no_escape_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gwm_pkg::CFG_PATHNAME:    path_mode_q   <= cfg_data_i[0];
        gwm_pkg::CFG_LEAD_PERIOD: lead_period_q <= cfg_data_i[0];
        gwm_pkg::CFG_NO_ESCAPE:   no_escape_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv = s1_valid_q &&
                  (s1_action_q != gwm_pkg::ACT_END || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_action_q <= gwm_pkg::action_e'(s_axis_tuser_i);
      s1_char_q   <= s_axis_tdata_i;
    end
  end

  // match set at the start of a subject: position 0 and every position
  // reachable through the leading stars
  always_comb begin
    for (int i = 0; i < NPOS; i++) begin
      start_set[i] = (CNT_W'(i) <= lead_stars_q);
    end
  end

  assign active_eff = at_start_q ? start_set : active_q;
  assign wild_ok    = !(path_mode_q && s1_char_q == gwm_pkg::CH_SLASH);

  always_comb begin
    step_raw  = '0;
    step_prop = '0;
    for (int i = 0; i < PAT_LEN; i++) begin
      if (tok_count_q > CNT_W'(i)) begin
        case (tok_kind_q[i])
          gwm_pkg::TK_LIT: begin
            if (active_eff[i] && tok_byte_q[i] == s1_char_q) step_raw[i+1] = 1'b1;
          end
          gwm_pkg::TK_ANY: begin
            if (active_eff[i] && wild_ok) step_raw[i+1] = 1'b1;
          end
          gwm_pkg::TK_STAR: begin
            if (active_eff[i] && wild_ok) step_raw[i] = 1'b1;
            step_prop[i+1] = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  gwm_star_closure #(
    .N (NPOS)
  ) u_closure (
    .raw_i    (step_raw),
    .prop_i   (step_prop),
    .closed_o (step_closed)
  );

  always_comb begin
    if (pat_ovf_q) begin
      end_status = gwm_pkg::ST_OVERFLOW;
    end else if (!period_fail_q && active_eff[tok_count_q]) begin
      end_status = gwm_pkg::ST_MATCH;
    end else begin
      end_status = gwm_pkg::ST_NOMATCH;
    end
  end

  // next state of pattern and subject
  always_comb begin
    tok_count_d   = tok_count_q;
    lead_stars_d  = lead_stars_q;
    esc_pend_d    = esc_pend_q;
    pat_ovf_d     = pat_ovf_q;
    at_start_d    = at_start_q;
    period_fail_d = period_fail_q;
    tok_we        = 1'b0;
    tok_waddr     = tok_count_q[IDX_W-1:0];
    tok_wkind     = gwm_pkg::TK_LIT;
    tok_wbyte     = s1_char_q;
    if (s1_adv) begin
      unique case (s1_action_q)
        gwm_pkg::ACT_CLEAR: begin
          tok_count_d   = '0;
          lead_stars_d  = '0;
          esc_pend_d    = 1'b0;
          pat_ovf_d     = 1'b0;
          at_start_d    = 1'b1;
          period_fail_d = 1'b0;
        end
        gwm_pkg::ACT_APPEND: begin
          at_start_d    = 1'b1;
          period_fail_d = 1'b0;
          if (esc_pend_q) begin
            // escaped byte replaces the backslash token, stays literal
            esc_pend_d = 1'b0;
            tok_we     = (tok_count_q != '0);
            tok_waddr  = IDX_W'(tok_count_q - CNT_W'(1));
          end else if (tok_count_q >= CNT_W'(PAT_LEN)) begin
            pat_ovf_d = 1'b1;
          end else begin
            tok_we      = 1'b1;
            tok_count_d = tok_count_q + CNT_W'(1);
            if (s1_char_q == gwm_pkg::CH_QUESTION) begin
              tok_wkind = gwm_pkg::TK_ANY;
              tok_wbyte = '0;
            end else if (s1_char_q == gwm_pkg::CH_STAR) begin
              tok_wkind = gwm_pkg::TK_STAR;
              tok_wbyte = '0;
              if (lead_stars_q == tok_count_q) lead_stars_d = lead_stars_q + CNT_W'(1);
            end else if (s1_char_q == gwm_pkg::CH_BACKSLASH && !no_escape_q) begin
              esc_pend_d = 1'b1;
            end
          end
        end
        gwm_pkg::ACT_SUBJECT: begin
          at_start_d = 1'b0;
          if (at_start_q && lead_period_q && s1_char_q == gwm_pkg::CH_PERIOD &&
              tok_count_q != '0 && tok_kind_q[0] != gwm_pkg::TK_LIT) begin
            period_fail_d = 1'b1;
          end
        end
        gwm_pkg::ACT_END: begin
          at_start_d    = 1'b1;
          period_fail_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_count_q   <= '0;
      lead_stars_q  <= '0;
      esc_pend_q    <= 1'b0;
      pat_ovf_q     <= 1'b0;
      at_start_q    <= 1'b1;
      period_fail_q <= 1'b0;
    end else begin
      tok_count_q   <= tok_count_d;
      lead_stars_q  <= lead_stars_d;
      esc_pend_q    <= esc_pend_d;
      pat_ovf_q     <= pat_ovf_d;
      at_start_q    <= at_start_d;
      period_fail_q <= period_fail_d;
    end
  end

  // match set is only read while at_start_q is low
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_action_q == gwm_pkg::ACT_SUBJECT) begin
      active_q <= step_closed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_we) begin
      tok_kind_q[tok_waddr] <= tok_wkind;
      tok_byte_q[tok_waddr] <= tok_wbyte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_action_q == gwm_pkg::ACT_END) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_action_q == gwm_pkg::ACT_END) begin
      out_status_q <= end_status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_status_q};

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_count_q <= CNT_W'(PAT_LEN))
    else $error("token count beyond pattern capacity");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_ovf_q |-> (tok_count_q == CNT_W'(PAT_LEN)))
    else $error("overflow flagged with room left");

  a_lead_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lead_stars_q <= tok_count_q)
    else $error("leading star run longer than pattern");

  a_end_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_action_q == gwm_pkg::ACT_END) |=> m_axis_tvalid_o)
    else $error("end word did not load output register");

endmodule

`default_nettype wire

// ===== tb/glob_match_checker.sv =====
`default_nettype none

module glob_match_checker #(
  parameter int PAT_LEN = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [0:0] cfg_data_i,
  input  wire logic       s_axis_tvalid_i,
  input  wire logic       s_axis_tready_i,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] char_byte
  input  wire logic [1:0] s_axis_tuser_i,   // [1:0] action
  input  wire logic       m_axis_tvalid_i,
  input  wire logic       m_axis_tready_i,
  input  wire logic [7:0] m_axis_tdata_i,   // [1:0] status, [7:2] zero
  output int              fail_count_o,
  output int              pending_o
);

  // predicted matcher state
  gwm_pkg::tok_kind_e tok_kind [PAT_LEN];
  logic [7:0]         tok_byte [PAT_LEN];
  int                 n_tok;
  bit                 esc_pend;
  bit                 too_long;
  bit                 at_start;
  bit                 lead_fail;
  logic [PAT_LEN:0]   live;
  bit                 mode_path;
  bit                 mode_period;
  bit                 mode_noesc;

  gwm_pkg::status_e   status_q [$];
  gwm_pkg::status_e   want_st;

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // a star may match nothing: each live star also lights the position after it
  function automatic logic [PAT_LEN:0] star_closure(logic [PAT_LEN:0] s);
    for (int i = 0; i < n_tok; i++)
      if (s[i] && tok_kind[i] == gwm_pkg::TK_STAR) s[i+1] = 1'b1;
    return s;
  endfunction

  function automatic void restart_subject();
    live      = star_closure({{PAT_LEN{1'b0}}, 1'b1});
    at_start  = 1'b1;
    lead_fail = 1'b0;
  endfunction

  function automatic void add_pattern_byte(logic [7:0] c);
    if (esc_pend) begin
      // escaped byte replaces the stored backslash, always literal
      if (n_tok > 0) begin
        tok_kind[n_tok-1] = gwm_pkg::TK_LIT;
        tok_byte[n_tok-1] = c;
      end
      esc_pend = 1'b0;
    end else if (n_tok >= PAT_LEN) begin
      too_long = 1'b1;
    end else begin
      tok_byte[n_tok] = 8'h00;
      if (c == gwm_pkg::CH_QUESTION) begin
        tok_kind[n_tok] = gwm_pkg::TK_ANY;
      end else if (c == gwm_pkg::CH_STAR) begin
        tok_kind[n_tok] = gwm_pkg::TK_STAR;
      end else begin
        tok_kind[n_tok] = gwm_pkg::TK_LIT;
        tok_byte[n_tok] = c;
        if (c == gwm_pkg::CH_BACKSLASH && !mode_noesc) esc_pend = 1'b1;
      end
      n_tok++;
    end
  endfunction

  function automatic void advance_subject(logic [7:0] c);
    logic [PAT_LEN:0] nxt;
    bit               wild_ok;
    wild_ok = !(mode_path && c == gwm_pkg::CH_SLASH);
    if (at_start && mode_period && c == gwm_pkg::CH_PERIOD && n_tok > 0 &&
        tok_kind[0] != gwm_pkg::TK_LIT)
      lead_fail = 1'b1;
    at_start = 1'b0;
    nxt = '0;
    for (int i = 0; i < n_tok; i++) begin
      if (live[i]) begin
        case (tok_kind[i])
          gwm_pkg::TK_LIT:  if (tok_byte[i] == c) nxt[i+1] = 1'b1;
          gwm_pkg::TK_ANY:  if (wild_ok) nxt[i+1] = 1'b1;
          gwm_pkg::TK_STAR: if (wild_ok) nxt[i] = 1'b1;
          default: ;
        endcase
      end
    end
    live = star_closure(nxt);
  endfunction

  function automatic void apply_word(gwm_pkg::action_e act, logic [7:0] c);
    case (act)
      gwm_pkg::ACT_CLEAR: begin
        n_tok    = 0;
        esc_pend = 1'b0;
        too_long = 1'b0;
        restart_subject();
      end
      gwm_pkg::ACT_APPEND: begin
        add_pattern_byte(c);
        restart_subject();
      end
      gwm_pkg::ACT_SUBJECT: advance_subject(c);
      default: begin
        if (too_long) status_q.push_back(gwm_pkg::ST_OVERFLOW);
        else if (!lead_fail && live[n_tok]) status_q.push_back(gwm_pkg::ST_MATCH);
        else status_q.push_back(gwm_pkg::ST_NOMATCH);
        restart_subject();
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_tok        = 0;
      esc_pend     = 1'b0;
      too_long     = 1'b0;
      mode_path    = 1'b0;
      mode_period  = 1'b0;
      mode_noesc   = 1'b0;
      restart_subject();
      status_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (gwm_pkg::cfg_idx_e'(cfg_idx_i))
          gwm_pkg::CFG_PATHNAME:    mode_path   = cfg_data_i[0];
          gwm_pkg::CFG_LEAD_PERIOD: mode_period = cfg_data_i[0];
          gwm_pkg::CFG_NO_ESCAPE:   mode_noesc  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (status_q.size() == 0) begin
          report_mismatch("status word with none expected", m_axis_tdata_i, -1);
        end else begin
          want_st = status_q.pop_front();
          if (m_axis_tdata_i[1:0] != want_st)
            report_mismatch("status", m_axis_tdata_i[1:0], want_st);
          if (m_axis_tdata_i[7:2] != '0)
            report_mismatch("tdata padding", m_axis_tdata_i[7:2], 0);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        apply_word(gwm_pkg::action_e'(s_axis_tuser_i), s_axis_tdata_i);
      pending_o = status_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/glob_wildcard_matcher_core_tb.sv =====
`default_nettype none

module glob_wildcard_matcher_core_tb;

  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 100;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       cfg_we   = 1'b0;
  logic [1:0] cfg_idx  = gwm_pkg::CFG_PATHNAME;
  logic [0:0] cfg_data = 1'b0;
  logic       s_valid  = 1'b0;
  logic       s_ready;
  logic [7:0] s_data   = 8'h00;   // [7:0] char_byte
  logic [1:0] s_user   = gwm_pkg::ACT_CLEAR;   // [1:0] action
  logic       m_valid;
  logic       m_ready  = 1'b0;
  logic [7:0] m_data;   // [1:0] status, [7:2] zero

  int         fail_count;
  int         pending;
  int         words_sent = 0;
  bit         tx_calm    = 1'b0;
  logic [7:0] pat_q  [$];
  logic [7:0] subj_q [$];

  glob_wildcard_matcher_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  glob_match_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // bytes with a meaning to the matcher come up often
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h61;
      2:       return 8'h62;
      3:       return gwm_pkg::CH_SLASH;
      4:       return gwm_pkg::CH_PERIOD;
      5:       return gwm_pkg::CH_BACKSLASH;
      6:       return gwm_pkg::CH_STAR;
      7:       return gwm_pkg::CH_QUESTION;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_word(gwm_pkg::action_e act, logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= b;
    do @(posedge clk_i); while (!s_ready);
    words_sent++;
  endtask

  // mode bits change only with the block idle and every status read back
  task automatic drain_and_write(bit path, bit period, bit noesc);
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= gwm_pkg::CFG_PATHNAME;
    cfg_data <= path;
    @(posedge clk_i);
    cfg_idx  <= gwm_pkg::CFG_LEAD_PERIOD;
    cfg_data <= period;
    @(posedge clk_i);
    cfg_idx  <= gwm_pkg::CFG_NO_ESCAPE;
    cfg_data <= noesc;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_glob_job(bit go_long);
    int               plen;
    int               pos;
    int               n_subj;
    logic [7:0]       b;
    gwm_pkg::action_e na;
    if (go_long || $urandom_range(0, 9) < 6) begin
      push_word(gwm_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
      pat_q.delete();
      if (go_long) plen = $urandom_range(64, 67);
      else if ($urandom_range(0, 14) == 0) plen = $urandom_range(60, 66);
      else plen = $urandom_range(0, 6);
    end else begin
      plen = $urandom_range(1, 2);
    end
    repeat (plen) begin
      b = pick_char();
      push_word(gwm_pkg::ACT_APPEND, b);
      pat_q.push_back(b);
    end
    // long patterns get a single subject
    n_subj = (pat_q.size() > 16) ? 1 : $urandom_range(1, 3);
    repeat (n_subj) begin
      // walk the pattern so that most subjects get deep into it
      subj_q.delete();
      pos = 0;
      while (pos < pat_q.size()) begin
        b = pat_q[pos];
        if (b == gwm_pkg::CH_BACKSLASH && pos + 1 < pat_q.size()) begin
          subj_q.push_back(pat_q[pos+1]);
          pos += 2;
        end else begin
          if (b == gwm_pkg::CH_QUESTION) subj_q.push_back(pick_char());
          else if (b == gwm_pkg::CH_STAR)
            repeat ($urandom_range(0, 2)) subj_q.push_back(pick_char());
          else subj_q.push_back(b);
          pos++;
        end
      end
      case ($urandom_range(0, 5))
        0: if (subj_q.size() > 0) subj_q[$urandom_range(0, subj_q.size() - 1)] = pick_char();
        1: subj_q.push_back(pick_char());
        2: if (subj_q.size() > 0) void'(subj_q.pop_back());
        default: ;
      endcase
      foreach (subj_q[i]) push_word(gwm_pkg::ACT_SUBJECT, subj_q[i]);
      // now and then the subject is left open and cut by the next word
      if ($urandom_range(0, 19) != 0)
        push_word(gwm_pkg::ACT_END, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) begin
      na = gwm_pkg::action_e'($urandom_range(0, 3));
      b  = 8'($urandom_range(0, 255));
      push_word(na, b);
      if (na == gwm_pkg::ACT_CLEAR) pat_q.delete();
      else if (na == gwm_pkg::ACT_APPEND) pat_q.push_back(b);
    end
  endtask

  // receiver: random stalls after each status word, calm stretches, long hold-offs
  initial begin
    int gap;
    int taken;
    int cyc;
    gap   = 0;
    taken = 0;
    cyc   = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (m_valid && m_ready) begin
        taken++;
        if (taken == 6 || taken % 60 == 30) gap = HOLD_CYCLES;
        else if ((cyc / 400) % 3 == 2) gap = 0;
        else gap = pick_gap();
      end else if (gap > 0) begin
        gap--;
      end
      m_ready <= (gap == 0);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [2:0] cb;
    int         start;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drain_and_write(1'b0, 1'b0, 1'b0);
    push_word(gwm_pkg::ACT_END, 8'h00);                 // empty pattern, empty subject
    push_word(gwm_pkg::ACT_SUBJECT, 8'hFF);
    push_word(gwm_pkg::ACT_END, 8'hFF);
    push_word(gwm_pkg::ACT_APPEND, gwm_pkg::CH_STAR);
    push_word(gwm_pkg::ACT_APPEND, gwm_pkg::CH_SLASH);
    push_word(gwm_pkg::ACT_SUBJECT, gwm_pkg::CH_SLASH); // star matches empty before slash
    push_word(gwm_pkg::ACT_END, 8'h00);
    push_word(gwm_pkg::ACT_CLEAR, 8'hA5);
    push_word(gwm_pkg::ACT_APPEND, gwm_pkg::CH_QUESTION);
    push_word(gwm_pkg::ACT_SUBJECT, 8'h00);
    push_word(gwm_pkg::ACT_END, 8'h00);
    push_word(gwm_pkg::ACT_APPEND, gwm_pkg::CH_BACKSLASH); // escape pending across a mode change
    drain_and_write(1'b1, 1'b1, 1'b1);
    push_word(gwm_pkg::ACT_APPEND, gwm_pkg::CH_STAR);   // stored as a literal star
    push_word(gwm_pkg::ACT_SUBJECT, gwm_pkg::CH_PERIOD);
    push_word(gwm_pkg::ACT_SUBJECT, gwm_pkg::CH_STAR);
    push_word(gwm_pkg::ACT_END, 8'h00);
    push_word(gwm_pkg::ACT_SUBJECT, gwm_pkg::CH_SLASH);
    push_word(gwm_pkg::ACT_SUBJECT, gwm_pkg::CH_STAR);
    push_word(gwm_pkg::ACT_END, 8'h00);
    push_word(gwm_pkg::ACT_SUBJECT, 8'h61);
    push_word(gwm_pkg::ACT_SUBJECT, gwm_pkg::CH_STAR);
    push_word(gwm_pkg::ACT_APPEND, gwm_pkg::CH_BACKSLASH); // cuts the subject; plain literal now
    push_word(gwm_pkg::ACT_SUBJECT, 8'h78);
    push_word(gwm_pkg::ACT_SUBJECT, gwm_pkg::CH_STAR);
    push_word(gwm_pkg::ACT_SUBJECT, gwm_pkg::CH_BACKSLASH);
    push_word(gwm_pkg::ACT_END, 8'h00);

    pat_q.delete();
    for (int ph = 0; ph < 10; ph++) begin
      cb = (ph < 8) ? ph[2:0] : 3'($urandom_range(0, 7));
      drain_and_write(cb[0], cb[1], cb[2]);
      tx_calm = (ph % 3 == 1);
      start   = words_sent;
      run_glob_job(ph == 2);
      while (words_sent - start < 15) run_glob_job(1'b0);
    end

    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
